[rtl/cbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg
// Types, constants and helper functions shared by the B-spline sampler.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int MAX_SAMPLES_DEF = 64;

  localparam logic [5:0] SUB_RESET = 6'd16;
  localparam logic [6:0] PTS_RESET = 7'd4;

  // Register indexes on the configuration port.
  localparam logic REG_SUBDIVISION = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 40;
  localparam int U_W       = 23;
  localparam int M_W       = 36;
  localparam int Q_DEPTH   = 2;
  localparam int LANES     = 4;

  // Rounded sum a+3 is clamped to the range that maps onto int32 after /6.
  localparam logic signed [ACC_W:0] N_LO = -41'sd12884901888;
  localparam logic signed [ACC_W:0] N_HI = 41'sd12884901887;

  // floor(v/3) for v < 48 equals floor(v*43/128).
  localparam logic [12:0] DIV3_MUL   = 13'd43;
  localparam int          DIV3_SHIFT = 7;

  typedef enum logic {
    OP_LOAD,
    OP_GEN
  } op_t;

  typedef struct packed {
    op_t          op;
    logic [5:0]   index;
    logic [127:0] point;   // {w, z, y, x}
  } cmd_t;

  typedef struct packed {
    logic [5:0] subdivision;
    logic [6:0] point_count;
  } cfg_t;

  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } q_status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_COEF,
    BK_MUL,
    BK_ADD,
    BK_SAT,
    BK_DIV3,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [3:0] q;
    logic [1:0] r;
  } div3_t;

  // One radix-16 digit of a long division by three.
  function automatic div3_t div3_nib(input logic [1:0] rem, input logic [3:0] d);
    logic [5:0]  v;
    logic [12:0] prod;
    div3_t       res;
    v     = {rem, d};
    prod  = 13'(v) * DIV3_MUL;
    res.q = prod[DIV3_SHIFT +: 4];
    res.r = 2'(v - 6'(res.q) * 6'd3);
    return res;
  endfunction

endpackage

[rtl/cbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cbs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cbs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module cbs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cbs_pkg::cmd_t       push_data,
  input  logic                pop,
  output logic                valid,
  output cbs_pkg::cmd_t       head,
  output cbs_pkg::q_status_t  status
);

  cbs_pkg::cmd_t entry [cbs_pkg::Q_DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign valid        = (count != 2'd0);
  assign head         = entry[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == 2'(cbs_pkg::Q_DEPTH));

endmodule

[rtl/cbs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_front
// Configuration registers, input acceptance and command classification.
// ----------------------------------------------------------------------------
module cbs_front #(
  parameter int MAX_POINTS = cbs_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [5:0]          point_index,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic signed [31:0]  point_w,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cbs_pkg::cfg_t       cfg,
  input  logic                q_full,
  output logic                q_push,
  output cbs_pkg::cmd_t       q_data
);

  logic [5:0] subdivision;
  logic [6:0] point_count;
  logic       wr_en;
  logic       keep;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      subdivision <= cbs_pkg::SUB_RESET;
      point_count <= cbs_pkg::PTS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        cbs_pkg::REG_SUBDIVISION: subdivision <= pwdata[5:0];
        cbs_pkg::REG_POINT_COUNT: point_count <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cbs_pkg::REG_SUBDIVISION: prdata = {26'd0, subdivision};
      cbs_pkg::REG_POINT_COUNT: prdata = {25'd0, point_count};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg.subdivision = subdivision;
  assign cfg.point_count = point_count;

  // Loads into slots beyond the store are dropped here.
  assign keep     = cmd || (int'(point_index) < MAX_POINTS);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

  assign q_data.op    = cmd ? cbs_pkg::OP_GEN : cbs_pkg::OP_LOAD;
  assign q_data.index = point_index;
  assign q_data.point = {point_w, point_z, point_y, point_x};

endmodule

[rtl/cbs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_back
// Executes queued commands: point store writes and curve sample generation.
// ----------------------------------------------------------------------------
module cbs_back #(
  parameter int MAX_POINTS  = cbs_pkg::MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = cbs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cbs_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  cbs_pkg::cmd_t       q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          sample_index,
  output logic signed [31:0]  curve_x,
  output logic signed [31:0]  curve_y,
  output logic signed [31:0]  curve_z,
  output logic signed [31:0]  curve_w,
  output logic                last_sample
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int SW     = ((AW > 7) ? AW : 7) + 1;
  localparam int PC_MAX = (MAX_POINTS > 127) ? 127 : MAX_POINTS;
  localparam int ACC_W  = cbs_pkg::ACC_W;
  localparam int M_W    = cbs_pkg::M_W;
  localparam int U_W    = cbs_pkg::U_W;
  localparam int LANES  = cbs_pkg::LANES;
  localparam int PW     = ACC_W + 18;

  cbs_pkg::bk_state_t state, state_next;

  logic [5:0]  sub_r;
  logic [6:0]  segs_r;
  logic [5:0]  sub_clamp;
  logic [6:0]  pts_clamp;

  logic [6:0]     rem_d;
  logic [U_W-1:0] dvd;
  logic [U_W-1:0] quo;
  logic [4:0]     dcnt;
  logic [6:0]     trial;
  logic           qbit;

  logic [U_W-1:0] stepq;
  logic [5:0]     stepr;
  logic [U_W-1:0] u_r;
  logic [5:0]     tr;
  logic [5:0]     idx;
  logic           is_last;
  logic [6:0]     seg_cur;
  logic [16:0]    t_cur;
  logic [6:0]     trs;
  logic           carry;

  logic [2:0]          rcnt;
  logic [1:0]          rsel;
  logic [1:0]          round;
  logic [1:0]          d3cnt;
  logic [127:0]        pt [4];
  logic signed [ACC_W-1:0] acc [LANES];
  logic signed [ACC_W-1:0] cf  [LANES][3];
  logic signed [PW-1:0]    prod [LANES];
  logic [M_W-1:0]      mq [LANES];
  logic [M_W-1:0]      qv [LANES];
  logic [1:0]          rem3 [LANES];

  logic           out_free;
  logic           load_out;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic [127:0]   ram_rdata;
  logic [SW-1:0]  raddr_sum;

  cbs_ram #(
    .WIDTH (128),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_head.point),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clamp configuration into the supported ranges.
  always_comb begin
    if (cfg.subdivision == 6'd0) begin
      sub_clamp = 6'd1;
    end else if (cfg.subdivision > 6'(MAX_SAMPLES - 1)) begin
      sub_clamp = 6'(MAX_SAMPLES - 1);
    end else begin
      sub_clamp = cfg.subdivision;
    end
    if (cfg.point_count < 7'd4) begin
      pts_clamp = 7'd4;
    end else if (cfg.point_count > 7'(PC_MAX)) begin
      pts_clamp = 7'(PC_MAX);
    end else begin
      pts_clamp = cfg.point_count;
    end
  end

  assign trial   = {rem_d[5:0], dvd[U_W-1]};
  assign qbit    = (trial >= {1'b0, sub_r});
  assign is_last = (idx == sub_r);
  assign seg_cur = is_last ? (segs_r - 7'd1) : u_r[U_W-1 -: 7];
  assign t_cur   = is_last ? 17'h10000 : {1'b0, u_r[15:0]};
  assign trs     = {1'b0, tr} + {1'b0, stepr};
  assign carry   = (trs >= {1'b0, sub_r});
  assign rsel    = 2'(rcnt - 3'd1);
  assign out_free = !out_valid || !out_stall;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      cbs_pkg::BK_IDLE: begin
        if (q_valid && q_head.op == cbs_pkg::OP_GEN) begin
          state_next = cbs_pkg::BK_DIV;
        end
      end
      cbs_pkg::BK_DIV:  if (dcnt == 5'(U_W - 1)) state_next = cbs_pkg::BK_READ;
      cbs_pkg::BK_READ: if (rcnt == 3'd4) state_next = cbs_pkg::BK_COEF;
      cbs_pkg::BK_COEF: state_next = cbs_pkg::BK_MUL;
      cbs_pkg::BK_MUL:  state_next = cbs_pkg::BK_ADD;
      cbs_pkg::BK_ADD:  state_next = (round == 2'd2) ? cbs_pkg::BK_SAT : cbs_pkg::BK_MUL;
      cbs_pkg::BK_SAT:  state_next = cbs_pkg::BK_DIV3;
      cbs_pkg::BK_DIV3: if (d3cnt == 2'd2) state_next = cbs_pkg::BK_EMIT;
      cbs_pkg::BK_EMIT: begin
        if (out_free) begin
          state_next = is_last ? cbs_pkg::BK_IDLE : cbs_pkg::BK_READ;
        end
      end
      default: state_next = cbs_pkg::BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    ram_waddr = AW'(q_head.index);
    raddr_sum = SW'(seg_cur) + SW'(rcnt);
    ram_raddr = AW'(raddr_sum);
    case (state)
      cbs_pkg::BK_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && (q_head.op == cbs_pkg::OP_LOAD);
      end
      cbs_pkg::BK_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cbs_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] p0, p1, p2, p3;
    logic signed [ACC_W:0]   n;
    logic [ACC_W:0]          nn;
    logic [1:0]              r;
    logic [11:0]             q12;
    cbs_pkg::div3_t          dr;
    case (state)
      cbs_pkg::BK_IDLE: begin
        sub_r  <= sub_clamp;
        segs_r <= pts_clamp - 7'd3;
        dvd    <= {pts_clamp - 7'd3, 16'd0};
        rem_d  <= 7'd0;
        quo    <= '0;
        dcnt   <= 5'd0;
      end
      cbs_pkg::BK_DIV: begin
        // One restoring step of (segs << 16) / sub per cycle.
        rem_d <= qbit ? (trial - {1'b0, sub_r}) : trial;
        dvd   <= {dvd[U_W-2:0], 1'b0};
        quo   <= {quo[U_W-2:0], qbit};
        dcnt  <= dcnt + 5'd1;
        if (dcnt == 5'(U_W - 1)) begin
          stepq <= {quo[U_W-2:0], qbit};
          stepr <= qbit ? 6'(trial - {1'b0, sub_r}) : 6'(trial);
          u_r   <= '0;
          tr    <= 6'd0;
          idx   <= 6'd0;
          rcnt  <= 3'd0;
        end
      end
      cbs_pkg::BK_READ: begin
        rcnt <= rcnt + 3'd1;
        if (rcnt != 3'd0) begin
          pt[rsel] <= ram_rdata;
        end
      end
      cbs_pkg::BK_COEF: begin
        round <= 2'd0;
        for (int l = 0; l < LANES; l++) begin
          p0 = ACC_W'($signed(pt[0][32*l +: 32]));
          p1 = ACC_W'($signed(pt[1][32*l +: 32]));
          p2 = ACC_W'($signed(pt[2][32*l +: 32]));
          p3 = ACC_W'($signed(pt[3][32*l +: 32]));
          acc[l]   <= -p0 + 3 * p1 - 3 * p2 + p3;
          cf[l][0] <= 3 * p0 - 6 * p1 + 3 * p2;
          cf[l][1] <= -3 * p0 + 3 * p2;
          cf[l][2] <= p0 + 4 * p1 + p2;
        end
      end
      cbs_pkg::BK_MUL: begin
        for (int l = 0; l < LANES; l++) begin
          prod[l] <= acc[l] * $signed({1'b0, t_cur});
        end
      end
      cbs_pkg::BK_ADD: begin
        round <= round + 2'd1;
        for (int l = 0; l < LANES; l++) begin
          acc[l] <= ACC_W'(prod[l] >>> cbs_pkg::FRAC_BITS) + cf[l][round];
        end
      end
      cbs_pkg::BK_SAT: begin
        d3cnt <= 2'd0;
        for (int l = 0; l < LANES; l++) begin
          n = (ACC_W + 1)'(acc[l]) + 41'sd3;
          if (n < cbs_pkg::N_LO) begin
            n = cbs_pkg::N_LO;
          end else if (n > cbs_pkg::N_HI) begin
            n = cbs_pkg::N_HI;
          end
          nn = n - cbs_pkg::N_LO;
          mq[l]   <= {2'b00, nn[34:1]};
          qv[l]   <= '0;
          rem3[l] <= 2'd0;
        end
      end
      cbs_pkg::BK_DIV3: begin
        d3cnt <= d3cnt + 2'd1;
        for (int l = 0; l < LANES; l++) begin
          r = rem3[l];
          for (int j = 0; j < 3; j++) begin
            dr = cbs_pkg::div3_nib(r, mq[l][M_W-1-4*j -: 4]);
            q12[11-4*j -: 4] = dr.q;
            r = dr.r;
          end
          rem3[l] <= r;
          mq[l]   <= {mq[l][M_W-13:0], 12'd0};
          qv[l]   <= {qv[l][M_W-13:0], q12};
        end
      end
      cbs_pkg::BK_EMIT: begin
        if (out_free) begin
          idx  <= idx + 6'd1;
          rcnt <= 3'd0;
          tr   <= carry ? 6'(trs - {1'b0, sub_r}) : 6'(trs);
          u_r  <= u_r + stepq + U_W'(carry);
        end
      end
      default: ;
    endcase
  end

  // Output register; the quotient is offset by 2^31, so its top bit flips.
  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_index <= idx;
      last_sample  <= is_last;
      curve_x      <= {~qv[0][31], qv[0][30:0]};
      curve_y      <= {~qv[1][31], qv[1][30:0]};
      curve_z      <= {~qv[2][31], qv[2][30:0]};
      curve_w      <= {~qv[3][31], qv[3][30:0]};
    end
  end

endmodule

[rtl/cubic_bspline_curve_sampler_unit.sv]
`timescale 1ns / 1ps
// Loads: one transfer per cycle into a two-entry queue while it has room; the back end
// pops a load while idle and writes it into the store. Generate: a dequeue and the
// setup division, then per sample the store reads, coefficients, three multiply-add
// rounds, saturation, three /6 digit steps and emit; the store has a single read port.
// The output is registered.
// Synchronous reset clears control and restores the register defaults; the store is kept.
// ----------------------------------------------------------------------------
// cubic_bspline_curve_sampler_unit
// Uniform cubic B-spline curve sampler, top level.
// ----------------------------------------------------------------------------
module cubic_bspline_curve_sampler_unit #(
  parameter int MAX_POINTS  = cbs_pkg::MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = cbs_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] point_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         sample_index,
  output logic signed [31:0] curve_x,
  output logic signed [31:0] curve_y,
  output logic signed [31:0] curve_z,
  output logic signed [31:0] curve_w,
  output logic               last_sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cbs_pkg::cfg_t      cfg;
  cbs_pkg::cmd_t      q_in;
  cbs_pkg::cmd_t      q_head;
  cbs_pkg::q_status_t q_stat;
  logic               q_push;
  logic               q_pop;
  logic               q_valid;

  cbs_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_w     (point_w),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg         (cfg),
    .q_full      (q_stat.full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  cbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .status    (q_stat)
  );

  cbs_back #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_index (sample_index),
    .curve_x      (curve_x),
    .curve_y      (curve_y),
    .curve_z      (curve_z),
    .curve_w      (curve_w),
    .last_sample  (last_sample)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (q_stat.count == 2'(cbs_pkg::Q_DEPTH)))
    else $error("input stalled while the command queue has room");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> q_valid)
    else $error("pushed command missing from the queue");

endmodule

[dv/tb_cubic_bspline_curve_sampler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bspline_curve_sampler_unit
// Self-checking bench for the cubic B-spline curve sampler. Loads fill a
// shadow point store; each accepted generate computes the expected samples
// in exact fixed point. A clocked monitor compares every sample in order,
// with random idling on both sides and register changes between phases.
// ----------------------------------------------------------------------------
module tb_cubic_bspline_curve_sampler_unit;

  typedef struct {
    cbs_pkg::op_t op;
    logic [5:0]   slot;
    logic [31:0]  px, py, pz, pw;
  } point_cmd_t;

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] cx, cy, cz, cw;
    logic        last;
  } sample_t;

  logic clk, rst;
  logic in_valid, in_stall, cmd;
  logic [5:0] point_index;
  logic signed [31:0] point_x, point_y, point_z, point_w;
  logic out_valid, out_stall;
  logic [5:0] sample_index;
  logic signed [31:0] curve_x, curve_y, curve_z, curve_w;
  logic last_sample;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  cubic_bspline_curve_sampler_unit dut (.*);

  point_cmd_t  pending_cmds[$];
  point_cmd_t  cur_cmd;
  sample_t     expected_samples[$];
  sample_t     got;
  logic [31:0] shadow_x[64], shadow_y[64], shadow_z[64], shadow_w[64];
  logic [5:0]  cfg_sub;
  logic [6:0]  cfg_pts;
  int          send_idle_pct, recv_idle_pct;
  int          errors;
  int          cycles;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // Horner evaluation of one component, floor semantics throughout.
  function automatic logic [31:0] spline_comp(logic [31:0] q0, logic [31:0] q1,
                                              logic [31:0] q2, logic [31:0] q3,
                                              longint t);
    longint p0, p1, p2, p3, c0, c1, c2, c3, a, n;
    p0 = sx(q0); p1 = sx(q1); p2 = sx(q2); p3 = sx(q3);
    c0 = -p0 + 3 * p1 - 3 * p2 + p3;
    c1 = 3 * p0 - 6 * p1 + 3 * p2;
    c2 = -3 * p0 + 3 * p2;
    c3 = p0 + 4 * p1 + p2;
    a = ((c0 * t) >>> 16) + c1;
    a = ((a * t) >>> 16) + c2;
    a = ((a * t) >>> 16) + c3;
    n = a + 3;
    n = (n >= 0) ? n / 6 : -((-n + 5) / 6);
    if (n > 64'sd2147483647) n = 64'sd2147483647;
    if (n < -64'sd2147483648) n = -64'sd2147483648;
    return n[31:0];
  endfunction

  task automatic predict_samples();
    int sub, pts, segs, num, seg;
    longint t;
    sample_t s;
    sub = (cfg_sub < 1) ? 1 : cfg_sub;
    pts = (cfg_pts < 4) ? 4 : ((cfg_pts > 64) ? 64 : cfg_pts);
    segs = pts - 3;
    for (int i = 0; i <= sub; i++) begin
      num = i * segs;
      seg = num / sub;
      t = (longint'(num % sub) * 65536) / sub;
      if (i == sub) begin
        seg = segs - 1;
        t = 65536;
      end
      s.idx = i[5:0];
      s.cx = spline_comp(shadow_x[seg], shadow_x[seg+1], shadow_x[seg+2], shadow_x[seg+3], t);
      s.cy = spline_comp(shadow_y[seg], shadow_y[seg+1], shadow_y[seg+2], shadow_y[seg+3], t);
      s.cz = spline_comp(shadow_z[seg], shadow_z[seg+1], shadow_z[seg+2], shadow_z[seg+3], t);
      s.cw = spline_comp(shadow_w[seg], shadow_w[seg+1], shadow_w[seg+2], shadow_w[seg+3], t);
      s.last = (i == sub);
      expected_samples = {expected_samples, s};
    end
  endtask

  // Driver: the accepted command updates the prediction, then the next one is offered.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_cmd.op == cbs_pkg::OP_LOAD) begin
          shadow_x[cur_cmd.slot] = cur_cmd.px;
          shadow_y[cur_cmd.slot] = cur_cmd.py;
          shadow_z[cur_cmd.slot] = cur_cmd.pz;
          shadow_w[cur_cmd.slot] = cur_cmd.pw;
        end else begin
          predict_samples();
        end
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          cmd <= cur_cmd.op;
          point_index <= cur_cmd.slot;
          point_x <= cur_cmd.px;
          point_y <= cur_cmd.py;
          point_z <= cur_cmd.pz;
          point_w <= cur_cmd.pw;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each transfer with the oldest expected sample.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample %0d", sample_index);
          errors++;
        end else begin
          got = expected_samples.pop_front();
          if (sample_index !== got.idx) begin
            $error("sample_index exp %0d got %0d", got.idx, sample_index); errors++;
          end
          if (curve_x !== got.cx) begin
            $error("curve_x exp %h got %h", got.cx, curve_x); errors++;
          end
          if (curve_y !== got.cy) begin
            $error("curve_y exp %h got %h", got.cy, curve_y); errors++;
          end
          if (curve_z !== got.cz) begin
            $error("curve_z exp %h got %h", got.cz, curve_z); errors++;
          end
          if (curve_w !== got.cw) begin
            $error("curve_w exp %h got %h", got.cw, curve_w); errors++;
          end
          if (last_sample !== got.last) begin
            $error("last_sample exp %0d got %0d", got.last, last_sample); errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_load(logic [5:0] slot, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z, logic [31:0] w);
    point_cmd_t c;
    c.op = cbs_pkg::OP_LOAD; c.slot = slot; c.px = x; c.py = y; c.pz = z; c.pw = w;
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic queue_generate();
    point_cmd_t c;
    c.op = cbs_pkg::OP_GEN; c.slot = 6'($urandom); c.px = $urandom; c.py = $urandom;
    c.pz = $urandom; c.pw = $urandom;
    pending_cmds = {pending_cmds, c};
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Loads leave no result behind, so the block gets extra cycles before a write.
  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(logic reg_idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(4 * reg_idx); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_idx == cbs_pkg::REG_SUBDIVISION) cfg_sub = value[5:0];
    else cfg_pts = value[6:0];
  endtask

  task automatic random_phase(int sidle, int ridle, int n);
    reg_write(cbs_pkg::REG_SUBDIVISION, $urandom_range(63));
    reg_write(cbs_pkg::REG_POINT_COUNT, ($urandom_range(3) == 0) ? $urandom_range(127)
                                                                   : $urandom_range(4, 12));
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(5) == 0) queue_generate();
      else queue_load(6'($urandom_range(63)), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord());
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; cmd = 1'b0; point_index = '0;
    point_x = '0; point_y = '0; point_z = '0; point_w = '0;
    out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_sub = cbs_pkg::SUB_RESET; cfg_pts = cbs_pkg::PTS_RESET;
    send_idle_pct = 12; recv_idle_pct = 70;
    errors = 0; cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Every slot gets written first so no generate can read an unwritten entry.
    for (int k = 0; k < 64; k++)
      queue_load(6'(k), $urandom, $urandom, $urandom, $urandom);
    queue_generate();
    // Alternating extremes drive the sums into saturation on both sides.
    queue_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    queue_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    queue_load(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF);
    queue_load(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
    queue_generate();
    drain();
    reg_write(cbs_pkg::REG_SUBDIVISION, 63);
    reg_write(cbs_pkg::REG_POINT_COUNT, 64);
    queue_generate();
    drain();
    // Zero subdivision and out-of-range counts are clamped by the block.
    reg_write(cbs_pkg::REG_SUBDIVISION, 0);
    reg_write(cbs_pkg::REG_POINT_COUNT, 127);
    queue_generate();
    drain();
    reg_write(cbs_pkg::REG_SUBDIVISION, 1);
    reg_write(cbs_pkg::REG_POINT_COUNT, 0);
    queue_generate();
    drain();

    random_phase(12, 70, 12);
    random_phase(70, 12, 12);
    random_phase(0, 0, 12);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
